// ----- hdl/sitda_pkg.sv -----
`default_nettype none

package sitda_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int DIGIT_COUNT_DEF = 10;

    localparam int NUMBER_W = 32;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // Per-cycle command shared by every digit cell.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic advance;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hdl/sitda_digit_cell.sv -----
`default_nettype none

module sitda_digit_cell (
    input  wire                            i_clk,
    input  sitda_pkg::t_cell_ctl           i_ctl,
    input  wire                            i_bit_in,
    input  wire  [sitda_pkg::DIGIT_W-1:0]  i_dig_in,
    output logic                           o_bit_out,
    output logic [sitda_pkg::DIGIT_W-1:0]  o_dig
);
    import sitda_pkg::*;

    logic [DIGIT_W-1:0] r_dig;
    logic [DIGIT_W-1:0] n_dig;
    logic [DIGIT_W-1:0] adj;

    // Add 3 to digits of 5 and up so the next left shift carries in decimal.
    assign adj       = (r_dig >= DIGIT_W'(5)) ? r_dig + DIGIT_W'(3) : r_dig;
    assign o_bit_out = adj[DIGIT_W-1];
    assign o_dig     = r_dig;

    always_comb begin
        n_dig = r_dig;
        if (i_ctl.clear) begin
            n_dig = '0;
        end else if (i_ctl.dabble) begin
            n_dig = {adj[DIGIT_W-2:0], i_bit_in};
        end else if (i_ctl.advance) begin
            n_dig = i_dig_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
    end

endmodule

`default_nettype wire

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text.
//
// Input channel: i_valid / o_stall carry one signed number per word. Only the
// low VALUE_BITS bits are used. Output channel: o_valid / i_stall carry one
// ASCII character per word (o_char_code), most significant first, with o_last
// on the final character. Negative values are led by '-', leading zeros are
// dropped, zero gives '0', and the most negative value gives no word at all.
//
// A row of DIGIT_COUNT BCD cells converts the magnitude by double-dabble, one
// bit per cycle. The same row then shifts its digits toward the top cell, one
// per cycle while the receiver does not stall; leading zeros are dropped as they
// reach the top cell and every other digit goes out as a character. One number
// is in work at a time; the next is accepted while the last character still
// waits in the output register.
//
// Reset clears the control state and the output valid. While i_stall is high and
// a word is pending, the output word holds and the character sequencer waits.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS  = sitda_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_COUNT = sitda_pkg::DIGIT_COUNT_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  signed [sitda_pkg::NUMBER_W-1:0] i_number,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [sitda_pkg::CHAR_W-1:0]     o_char_code,
    output logic                             o_last
);
    import sitda_pkg::*;

    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W = $clog2(DIGIT_COUNT + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [LEFT_W-1:0]       r_left, n_left;
    logic                    r_sign_pend, n_sign_pend;
    logic                    r_started, n_started;
    logic                    r_o_valid, n_o_valid;
    logic [CHAR_W-1:0]       r_o_char, n_o_char;
    logic                    r_o_last, n_o_last;

    logic signed [VALUE_BITS-1:0] raw;
    logic                    most_neg;
    logic                    accept;
    logic                    out_free;
    t_cell_ctl               cell_ctl;

    logic [DIGIT_COUNT:0]    w_carry;
    logic [DIGIT_W-1:0]      w_dig [DIGIT_COUNT];
    logic [DIGIT_W-1:0]      top_dig;

    assign raw      = VALUE_BITS'(i_number);
    assign most_neg = raw[VALUE_BITS-1] && (raw[VALUE_BITS-2:0] == '0);
    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign top_dig  = w_dig[DIGIT_COUNT-1];
    assign w_carry[0] = r_mag[VALUE_BITS-1];

    genvar k;
    generate
        for (k = 0; k < DIGIT_COUNT; k++) begin : g_cell
            logic [DIGIT_W-1:0] dig_in;
            if (k == 0) begin : g_low
                assign dig_in = '0;
            end else begin : g_up
                assign dig_in = w_dig[k-1];
            end
            sitda_digit_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (cell_ctl),
                .i_bit_in  (w_carry[k]),
                .i_dig_in  (dig_in),
                .o_bit_out (w_carry[k+1]),
                .o_dig     (w_dig[k])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_sign_pend = r_sign_pend;
        n_started   = r_started;
        n_o_valid   = r_o_valid && i_stall;
        n_o_char    = r_o_char;
        n_o_last    = r_o_last;
        cell_ctl    = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept && !most_neg) begin
                    cell_ctl.clear = 1'b1;
                    n_neg   = raw[VALUE_BITS-1];
                    n_mag   = raw[VALUE_BITS-1] ? VALUE_BITS'(-raw) : VALUE_BITS'(raw);
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                cell_ctl.dabble = 1'b1;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_left      = LEFT_W'(DIGIT_COUNT);
                    n_sign_pend = r_neg;
                    n_started   = 1'b0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_sign_pend) begin
                        n_o_valid   = 1'b1;
                        n_o_char    = CHAR_MINUS;
                        n_o_last    = 1'b0;
                        n_sign_pend = 1'b0;
                    end else if (!r_started && top_dig == '0 && r_left > LEFT_W'(1)) begin
                        // drop a leading zero
                        cell_ctl.advance = 1'b1;
                        n_left = r_left - LEFT_W'(1);
                    end else begin
                        cell_ctl.advance = 1'b1;
                        n_o_valid = 1'b1;
                        n_o_char  = CHAR_ZERO + CHAR_W'(top_dig);
                        n_o_last  = (r_left == LEFT_W'(1));
                        n_started = 1'b1;
                        n_left    = r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_cnt       <= n_cnt;
        r_left      <= n_left;
        r_sign_pend <= n_sign_pend;
        r_started   <= n_started;
        r_o_char    <= n_o_char;
        r_o_last    <= n_o_last;
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_last      = r_o_last;

endmodule

`default_nettype wire

// ----- tb/signed_int_to_decimal_ascii_test.sv -----
`default_nettype none

module signed_int_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sitda_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    typedef struct {
        logic signed [NUMBER_W-1:0] number;
        bit                         typed;
        string                      text;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 108;
    localparam int CALM_ITEMS    = 25;
    localparam int DRAIN_CYCLES  = 60;

    localparam logic signed [NUMBER_W-1:0] MOST_NEGATIVE = 32'sh80000000;

    // Rows with text typed in carry their expected characters; the rest go
    // through the decimal predictor.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{32'sd0,           1'b1, "0"},
        '{32'sd1,           1'b1, "1"},
        '{-32'sd1,          1'b1, "-1"},
        '{32'sd9,           1'b1, "9"},
        '{32'sd10,          1'b1, "10"},
        '{-32'sd10,         1'b1, "-10"},
        '{32'sd99,          1'b0, ""},
        '{32'sd100,         1'b1, "100"},
        '{32'sd100000000,   1'b1, "100000000"},
        '{32'sd999999999,   1'b1, "999999999"},
        '{32'sd1000000000,  1'b1, "1000000000"},
        '{-32'sd1000000000, 1'b1, "-1000000000"},
        '{32'sd1000000001,  1'b0, ""},
        '{32'sd2147483647,  1'b1, "2147483647"},
        '{-32'sd2147483647, 1'b1, "-2147483647"},
        '{MOST_NEGATIVE,    1'b1, ""},
        '{32'sd2000000000,  1'b1, "2000000000"},
        '{32'sd1234567890,  1'b0, ""},
        '{-32'sd987654321,  1'b0, ""},
        '{32'sh55555555,    1'b0, ""},
        '{32'shAAAAAAAA,    1'b0, ""},
        '{-32'sd2,          1'b1, "-2"}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [NUMBER_W-1:0] i_number;
    logic                       o_valid;
    logic                       i_stall;
    logic [CHAR_W-1:0]          o_char_code;
    logic                       o_last;

    t_text_char pending_chars [$];
    bit         calm;
    bit         cur_typed;
    string      cur_text;
    int         fail_count;
    int         numbers_sent;
    int         negatives_sent;
    int         silent_sent;
    int         chars_checked;

    signed_int_to_decimal_ascii u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Queue the decimal text of one number: sign, digits without leading
    // zeros, last flag on the final digit. The most negative value has none.
    function automatic void predict_decimal_text(input logic signed [NUMBER_W-1:0] number);
        logic [NUMBER_W-1:0] magnitude;
        logic [3:0]          digits [DIGIT_COUNT_DEF];
        int                  first;
        t_text_char          ch;
        if (number == MOST_NEGATIVE)
            return;
        magnitude = number[NUMBER_W-1] ? NUMBER_W'(-number) : NUMBER_W'(number);
        for (int i = DIGIT_COUNT_DEF - 1; i >= 0; i--) begin
            digits[i] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
        end
        first = 0;
        while (first < DIGIT_COUNT_DEF - 1 && digits[first] == 4'd0)
            first++;
        if (number[NUMBER_W-1]) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int i = first; i < DIGIT_COUNT_DEF; i++) begin
            ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
            ch.last = (i == DIGIT_COUNT_DEF - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    function automatic void queue_typed_text(input string text);
        t_text_char ch;
        byte        b;
        for (int i = 0; i < text.len(); i++) begin
            b       = text[i];
            ch.code = b[CHAR_W-1:0];
            ch.last = (i == text.len() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Mix of magnitudes so that every text length shows up, with powers of
    // ten and their neighbors for the leading-zero logic.
    function automatic logic signed [NUMBER_W-1:0] random_number();
        logic [NUMBER_W-1:0] value;
        logic [NUMBER_W-1:0] power;
        int                  exponent;
        case ($urandom_range(0, 9))
            0, 1: value = $urandom;
            2: value = $urandom_range(0, 99);
            3: begin
                exponent = $urandom_range(0, 9);
                power    = 1;
                for (int i = 0; i < exponent; i++)
                    power = power * 10;
                value = power + $urandom_range(0, 2) - 1;
            end
            4: value = ($urandom_range(0, 3) == 0) ? MOST_NEGATIVE : 32'h7FFFFFFF;
            default: value = $urandom >> $urandom_range(0, 31);
        endcase
        if (value != MOST_NEGATIVE && $urandom_range(0, 1) == 1)
            value = -value;
        return value;
    endfunction

    task automatic send_number(input logic signed [NUMBER_W-1:0] number, input bit typed,
                               input string text);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid  = 1'b0;
            i_number = $urandom;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_number  = number;
        cur_typed = typed;
        cur_text  = text;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_pending();
        while (pending_chars.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver stalls in bursts until the calm tail of the run.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                numbers_sent++;
                if (i_number[NUMBER_W-1])
                    negatives_sent++;
                if (i_number == MOST_NEGATIVE)
                    silent_sent++;
                if (cur_typed)
                    queue_typed_text(cur_text);
                else
                    predict_decimal_text(i_number);
            end
            if (o_valid && !i_stall) begin
                chars_checked++;
                if (pending_chars.size() == 0) begin
                    $error("unexpected word: char_code %0d last %0b", o_char_code, o_last);
                    fail_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_char_code !== want.code) begin
                        $error("char_code: expected %0d, got %0d", want.code, o_char_code);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_number       = '0;
        cur_typed      = 1'b0;
        cur_text       = "";
        calm           = 1'b0;
        fail_count     = 0;
        numbers_sent   = 0;
        negatives_sent = 0;
        silent_sent    = 0;
        chars_checked  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_number(directed_rows[k].number, directed_rows[k].typed, directed_rows[k].text);

        // Hold off the sender until the receiver has drained every word.
        @(negedge i_clk);
        i_valid = 1'b0;
        drain_pending();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_number(random_number(), 1'b0, "");
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers (%0d negative, %0d most-negative with no text),",
                 numbers_sent, negatives_sent, silent_sent);
        $display("checked %0d characters under random sender gaps and receiver stalls.",
                 chars_checked);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
